@@ src/krm_pkg.sv @@
// Shared types, constants and codes for the keystroke rate meter.
`default_nettype none

package krm_pkg;

    // Ring depth default and fixed field widths
    localparam int RING_DEPTH_DEF = 64;
    localparam int TIME_W         = 32;
    localparam int WINDOW_W       = 16;
    localparam int MULT_W         = 4;
    localparam int RATE_W         = 8;
    localparam int SUM_W          = 32;
    localparam int TICK_W         = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;
    localparam int DIV_CNT_W      = $clog2(SUM_W);

    // Register reset values and limits
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2000;
    localparam logic [MULT_W-1:0]   MULT_RESET   = 4'd6;
    localparam logic [TICK_W-1:0]   TICK_LIMIT   = 16'hFFFE;
    localparam logic [RATE_W-1:0]   RATE_MAX     = 8'hFF;

    // Operation codes
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 1'b1;

    // Input request and result payloads
    typedef struct packed {
        logic [1:0]        operation;
        logic [TIME_W-1:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [RATE_W-1:0] rate_now;
        logic [RATE_W-1:0] rate_average;
        logic [RATE_W-1:0] rate_peak;
    } t_out_item;

    // One stored press
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] time_ms;
    } t_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RATE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

@@ src/krm_cell.sv @@
// One press-time cell of the ring; loads its neighbor's entry on a shift.
`default_nettype none

module krm_cell
    import krm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_shift,
    input  wire t_entry i_entry,
    output t_entry      o_entry
);

    logic              r_valid;
    logic [TIME_W-1:0] r_time;

    // Valid bit is control state, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    // Stored time, payload only
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_time <= i_entry.time_ms;
        end
    end

    assign o_entry.valid   = r_valid;
    assign o_entry.time_ms = r_time;

endmodule

`default_nettype wire

@@ src/krm_div.sv @@
// Serial restoring divider: running sum over tick count, one quotient bit a cycle.
`default_nettype none

module krm_div
    import krm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_dividend,
    input  wire logic [TICK_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [SUM_W-1:0]       o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [TICK_W:0]      r_rem;
    logic [TICK_W-1:0]    r_div;

    logic [TICK_W:0] trial;
    logic            fits;

    // Trial subtraction of the divisor from the shifted remainder
    assign trial = {r_rem[TICK_W-1:0], r_quo[SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ src/keystroke_rate_meter.sv @@
// Top level of the keystroke rate meter: press ring, scan sequencer, statistics.
//
// Key presses enter a chain of RING_DEPTH cells at the head; the oldest press
// drops off the far end. A tick rotates the whole chain once past a single age
// comparator, scales and saturates the count, updates peak, sum and tick count,
// then runs a serial 32-by-16 division for the average and presents the result.
// No new request is taken until that result is in the output register. Releases
// and unused codes are taken and give no result. The result sits in an output
// register, so presses are taken while it waits. Configuration writes are taken
// at any time.
`default_nettype none

module keystroke_rate_meter
    import krm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SCAN_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int HIT_W  = $clog2(RING_DEPTH + 1);
    localparam int PROD_W = HIT_W + MULT_W;

    t_state r_state, n_state;

    logic [WINDOW_W-1:0] r_window;
    logic [MULT_W-1:0]   r_mult;
    logic [TIME_W-1:0]   r_now;
    logic [SCAN_W-1:0]   r_scan;
    logic [HIT_W-1:0]    r_hits;
    logic [RATE_W-1:0]   r_rate;
    logic [RATE_W-1:0]   r_peak;
    logic [SUM_W-1:0]    r_sum;
    logic [TICK_W-1:0]   r_ticks;
    logic                r_out_valid;
    t_out_item           r_out_data;

    t_entry cell_out [RING_DEPTH];
    t_entry cell_in  [RING_DEPTH];

    logic in_accept, press_in, tick_in;
    logic ring_shift, scanning, div_start, out_load, out_free;
    logic scan_last, hit;
    logic [TIME_W-1:0]  age;
    logic [PROD_W-1:0]  product;
    logic [RATE_W-1:0]  rate_sat;
    logic [RATE_W-1:0]  avg_sat;
    logic [SUM_W-1:0]   n_sum;
    logic [TICK_W-1:0]  n_ticks;
    logic               div_done;
    logic [SUM_W-1:0]   quotient;

    // Request decode
    assign in_accept = i_in_valid && o_in_ready;
    assign press_in  = in_accept && (i_in_data.operation == OP_PRESS);
    assign tick_in   = in_accept && (i_in_data.operation == OP_TICK);
    assign out_free  = !r_out_valid || i_out_ready;
    assign scan_last = (r_scan == SCAN_W'(RING_DEPTH - 1));

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_mult   <= MULT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW: r_window <= i_cfg_data;
                CFG_MULT:   r_mult   <= i_cfg_data[MULT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Cell chain: a press enters at the head, a scan rotates the tail back in
    assign ring_shift = press_in || scanning;

    always_comb begin
        cell_in[0].valid   = press_in ? 1'b1 : cell_out[RING_DEPTH-1].valid;
        cell_in[0].time_ms = press_in ? i_in_data.time_ms : cell_out[RING_DEPTH-1].time_ms;
        for (int k = 1; k < RING_DEPTH; k++) begin
            cell_in[k] = cell_out[k-1];
        end
    end

    for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
        krm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (ring_shift),
            .i_entry (cell_in[g]),
            .o_entry (cell_out[g])
        );
    end

    // Age test at the chain tail
    assign age = r_now - cell_out[RING_DEPTH-1].time_ms;
    assign hit = cell_out[RING_DEPTH-1].valid && (age <= {{(TIME_W-WINDOW_W){1'b0}}, r_window});

    // Scale and saturate
    assign product  = r_hits * PROD_W'(r_mult);
    assign rate_sat = (product > PROD_W'(RATE_MAX)) ? RATE_MAX : product[RATE_W-1:0];

    // Running statistics next values
    assign n_sum   = r_sum + {{(SUM_W-RATE_W){1'b0}}, r_rate};
    assign n_ticks = (r_ticks != TICK_LIMIT) ? (r_ticks + 1'b1) : r_ticks;
    assign avg_sat = (|quotient[SUM_W-1:RATE_W]) ? RATE_MAX : quotient[RATE_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (tick_in) n_state = ST_SCAN;
            ST_SCAN: if (scan_last) n_state = ST_RATE;
            ST_RATE: n_state = ST_ACC;
            ST_ACC:  n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        scanning   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SCAN: scanning   = 1'b1;
            ST_RATE: ;
            ST_ACC:  div_start  = 1'b1;
            ST_DIV:  ;
            ST_OUT:  out_load   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan counters
    always_ff @(posedge i_clk) begin
        if (tick_in) begin
            r_now  <= i_in_data.time_ms;
            r_scan <= '0;
            r_hits <= '0;
        end else if (scanning) begin
            r_scan <= r_scan + 1'b1;
            r_hits <= r_hits + HIT_W'(hit);
        end
    end

    // Rate register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RATE) begin
            r_rate <= rate_sat;
        end
    end

    // Peak, sum and tick count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_ticks <= '0;
        end else if (div_start) begin
            if (r_rate > r_peak) begin
                r_peak <= r_rate;
            end
            r_sum   <= n_sum;
            r_ticks <= n_ticks;
        end
    end

    // Average divider
    krm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_ticks),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.rate_now     <= r_rate;
            r_out_data.rate_average <= avg_sat;
            r_out_data.rate_peak    <= r_peak;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the keystroke rate meter: random requests, predicted readings.
`timescale 1ns / 100ps

module tb;
    import krm_pkg::*;

    localparam int          CLK_PERIOD      = 12;
    localparam int          RESET_CYCLES    = 11;
    localparam int unsigned RANDOM_REQUESTS = 800;
    localparam int          SETTLE_CYCLES   = 128;
    localparam int          STALL_LIMIT     = 2000;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    // Tracks press history and running statistics; holds the readings still owed
    class rate_tracker;
        logic [TIME_W-1:0]   press_stamp [RING_DEPTH_DEF];
        bit                  press_seen  [RING_DEPTH_DEF];
        int unsigned         slot;
        logic [RATE_W-1:0]   peak;
        logic [SUM_W-1:0]    total;
        logic [TICK_W-1:0]   ticks;
        logic [WINDOW_W-1:0] window;
        logic [MULT_W-1:0]   mult;
        t_out_item           expected_readings [$];
        int unsigned         fail_count;

        function void clear();
            foreach (press_stamp[i]) begin
                press_stamp[i] = '0;
                press_seen[i]  = 1'b0;
            end
            slot       = 0;
            peak       = '0;
            total      = '0;
            ticks      = '0;
            window     = WINDOW_RESET;
            mult       = MULT_RESET;
            fail_count = 0;
            expected_readings.delete();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_WINDOW) begin
                window = value[WINDOW_W-1:0];
            end else begin
                mult = value[MULT_W-1:0];
            end
        endfunction

        // Presses go into the ring; a tick produces one reading
        function void note_request(t_in_item req);
            logic [TIME_W-1:0] age;
            int                hits;
            int                scaled;
            logic [SUM_W-1:0]  quotient;
            t_out_item         reading;
            case (req.operation)
                OP_PRESS: begin
                    press_stamp[slot] = req.time_ms;
                    press_seen[slot]  = 1'b1;
                    slot = (slot + 1) % RING_DEPTH_DEF;
                end
                OP_TICK: begin
                    hits = 0;
                    for (int i = 0; i < RING_DEPTH_DEF; i++) begin
                        // age wraps mod 2^32, so a press just ahead of the tick never counts
                        age = req.time_ms - press_stamp[i];
                        if (press_seen[i] && age <= TIME_W'(window)) hits++;
                    end
                    scaled = hits * int'(mult);
                    if (scaled > int'(RATE_MAX)) scaled = int'(RATE_MAX);
                    reading.rate_now = RATE_W'(scaled);
                    if (reading.rate_now > peak) peak = reading.rate_now;
                    total = total + SUM_W'(reading.rate_now);
                    if (ticks < TICK_LIMIT) ticks++;
                    quotient = total / SUM_W'(ticks);
                    reading.rate_average = (quotient > SUM_W'(RATE_MAX)) ?
                                           RATE_MAX : RATE_W'(quotient);
                    reading.rate_peak = peak;
                    expected_readings.push_back(reading);
                end
                default: begin
                    // release and unused code: no effect
                end
            endcase
        endfunction

        function void compare_field(string field, logic [RATE_W-1:0] want,
                                    logic [RATE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: rate_now %0d rate_average %0d rate_peak %0d",
                       got.rate_now, got.rate_average, got.rate_peak);
                fail_count++;
                return;
            end
            want = expected_readings.pop_front();
            compare_field("rate_now", want.rate_now, got.rate_now);
            compare_field("rate_average", want.rate_average, got.rate_average);
            compare_field("rate_peak", want.rate_peak, got.rate_peak);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  cfg_ready;

    rate_tracker board;
    bit          in_calm  = 1'b0;
    bit          out_calm = 1'b0;
    int unsigned counted_requests = 0;
    int          idle_cycles = 0;

    keystroke_rate_meter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pick_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // One request; valid stays up after acceptance until the next call decides
    task automatic send_request(logic [1:0] op, logic [TIME_W-1:0] stamp);
        int       gap;
        t_in_item req;
        gap = pick_gap(in_calm);
        req.operation = op;
        req.time_ms   = stamp;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        board.note_request(req);
        counted_requests++;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        board.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain: stop requests, wait for owed readings, then let the bench idle before the next step
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.expected_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side with random back-pressure
    initial begin
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            gap = pick_gap(out_calm);
            @(negedge clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            board.check_reading(out_data);
        end
    end

    // Watchdog on cycles with no handshake anywhere
    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_ready && out_valid === 1'b1) ||
            (cfg_valid && cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int unsigned           burst;
        int unsigned           span;
        int unsigned           pick;
        logic [TIME_W-1:0]     stamp;
        logic [CFG_DATA_W-1:0] setting;
        logic [MULT_W-1:0]     nib;
        board = new;
        board.clear();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty ring, ignored codes, window edge, future press, wrap
        send_request(OP_TICK, 32'd0);
        send_request(OP_RELEASE, 32'd5);
        send_request(OP_UNUSED, 32'd7);
        send_request(OP_PRESS, 32'd1000);
        send_request(OP_PRESS, 32'd1500);
        send_request(OP_PRESS, 32'd3000);
        send_request(OP_TICK, 32'd2500);
        send_request(OP_TICK, 32'd5000);
        send_request(OP_TICK, 32'd5001);
        send_request(OP_PRESS, 32'hFFFF_FFF0);
        send_request(OP_TICK, 32'h0000_0010);
        send_request(OP_PRESS, 32'hFFFF_FFFF);
        send_request(OP_TICK, 32'hFFFF_FFFF);

        // Zero window: only presses at the tick's own time count
        settle();
        write_register(CFG_WINDOW, 16'd0);
        write_register(CFG_MULT, 16'd1);
        send_request(OP_PRESS, 32'd777);
        send_request(OP_PRESS, 32'd778);
        send_request(OP_TICK, 32'd777);

        // Zero multiplier
        settle();
        write_register(CFG_MULT, 16'd0);
        send_request(OP_TICK, 32'd778);

        // Widest window, largest multiplier (upper data bits set)
        settle();
        write_register(CFG_WINDOW, 16'hFFFF);
        write_register(CFG_MULT, 16'hFFFF);
        send_request(OP_TICK, 32'd40000);

        // Random bursts of press, tick, release and unused-code traffic around a moving clock
        while (counted_requests < RANDOM_REQUESTS) begin
            settle();
            pick = $urandom_range(0, 3);
            if (pick[0]) begin
                case ($urandom_range(0, 5))
                    0:       setting = 16'd0;
                    1:       setting = 16'd1;
                    2:       setting = 16'hFFFF;
                    5:       setting = 16'($urandom());
                    default: setting = 16'($urandom_range(50, 4000));
                endcase
                write_register(CFG_WINDOW, setting);
            end
            if (pick[1]) begin
                case ($urandom_range(0, 3))
                    0:       nib = 4'd0;
                    1:       nib = 4'd1;
                    2:       nib = 4'd15;
                    default: nib = 4'($urandom_range(0, 15));
                endcase
                write_register(CFG_MULT, {12'($urandom()), nib});
            end
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);

            burst = $urandom_range(20, 60);
            span  = (int'(board.window) >> 3) + 2;
            if ($urandom_range(0, 3) == 0) begin
                stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
            end else begin
                stamp = $urandom();
            end
            repeat (burst) begin
                stamp = stamp + 32'($urandom_range(0, span));
                pick  = $urandom_range(0, 99);
                if (pick < 8) begin
                    // stray press at an arbitrary time
                    send_request(OP_PRESS, $urandom());
                end else if (pick < 55) begin
                    send_request(OP_PRESS, stamp);
                end else if (pick < 59) begin
                    send_request(OP_RELEASE, $urandom());
                end else if (pick < 62) begin
                    send_request(OP_UNUSED, $urandom());
                end else if (pick < 66) begin
                    send_request(OP_TICK, $urandom());
                end else begin
                    send_request(OP_TICK, stamp);
                end
            end
        end

        settle();
        if (board.fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/krm_pkg.sv
src/krm_cell.sv
src/krm_div.sv
src/keystroke_rate_meter.sv
tb/sv/tb.sv
